// ===== sv/cds_pkg.sv =====
`default_nettype none

package cds_pkg;

    // Field widths of the request and response items.
    localparam int REQ_W   = 3;
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int AMT_W   = 16;
    localparam int WDAY_W  = 3;
    localparam int STAT_W  = 2;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_LOAD         = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADD_DAYS     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ADD_MONTHS   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ADD_YEARS    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_NEXT_WEEKDAY = 3'd4;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID  = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

    // One request item.
    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [YEAR_W-1:0]  in_year;
        logic [MONTH_W-1:0] in_month;
        logic [DAY_W-1:0]   in_day;
        logic [AMT_W-1:0]   amount;
    } req_t;

    // One response item.
    typedef struct packed {
        logic [YEAR_W-1:0]  out_year;
        logic [MONTH_W-1:0] out_month;
        logic [DAY_W-1:0]   out_day;
        logic [WDAY_W-1:0]  weekday;
        logic [STAT_W-1:0]  status;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic load;
        logic set_invalid;
        logic saturate;
        logic step_day;
        logic step_month;
        logic spill;
        logic add_years;
        logic feb_fix;
        logic cnt_dec;
        logic wk_s1;
        logic wk_s2;
        logic wk_s3;
        logic rsp_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             cnt_zero;
        logic             load_ok;
        logic             day_ovf;
        logic             month_ovf;
        logic             years_ovf;
        logic             need_spill;
        logic             weekend;
        logic             overflowed;
    } sts_t;

endpackage

`default_nettype wire

// ===== sv/cds_ctrl.sv =====
`default_nettype none

module cds_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    input  wire cds_pkg::sts_t sts,
    output cds_pkg::cmd_t      cmd
);
    import cds_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DAYS,
        S_MONTHS,
        S_MCHK,
        S_YADD,
        S_YWAIT,
        S_YFIX,
        S_NWSTEP,
        S_WK1,
        S_WK2,
        S_WK3,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    // Next state and command decode.
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.req)
                    REQ_LOAD:
                    begin
                        if (sts.load_ok)
                            cmd.load = 1'b1;
                        else
                            cmd.set_invalid = 1'b1;
                        state_next = S_WK1;
                    end
                    REQ_ADD_DAYS:     state_next = S_DAYS;
                    REQ_ADD_MONTHS:   state_next = S_MONTHS;
                    REQ_ADD_YEARS:    state_next = S_YADD;
                    REQ_NEXT_WEEKDAY: state_next = S_NWSTEP;
                    default:          state_next = S_WK1;
                endcase
            end
            S_DAYS:
            begin
                if (sts.cnt_zero)
                    state_next = S_WK1;
                else if (sts.day_ovf)
                begin
                    cmd.saturate = 1'b1;
                    state_next   = S_WK1;
                end
                else
                begin
                    cmd.step_day = 1'b1;
                    cmd.cnt_dec  = 1'b1;
                end
            end
            S_MONTHS:
            begin
                if (sts.cnt_zero)
                    state_next = S_MCHK;
                else if (sts.month_ovf)
                begin
                    cmd.saturate = 1'b1;
                    state_next   = S_WK1;
                end
                else
                begin
                    cmd.step_month = 1'b1;
                    cmd.cnt_dec    = 1'b1;
                end
            end
            S_MCHK:
            begin
                // An overlong day spills into the following month.
                if (sts.need_spill)
                begin
                    if (sts.month_ovf)
                        cmd.saturate = 1'b1;
                    else
                        cmd.spill = 1'b1;
                end
                state_next = S_WK1;
            end
            S_YADD:
            begin
                if (sts.years_ovf)
                begin
                    cmd.saturate = 1'b1;
                    state_next   = S_WK1;
                end
                else
                begin
                    cmd.add_years = 1'b1;
                    state_next    = S_YWAIT;
                end
            end
            S_YWAIT:
            begin
                // The leap flag of the new year settles here.
                state_next = S_YFIX;
            end
            S_YFIX:
            begin
                cmd.feb_fix = 1'b1;
                state_next  = S_WK1;
            end
            S_NWSTEP:
            begin
                if (sts.day_ovf)
                    cmd.saturate = 1'b1;
                else
                    cmd.step_day = 1'b1;
                state_next = S_WK1;
            end
            S_WK1:
            begin
                cmd.wk_s1  = 1'b1;
                state_next = S_WK2;
            end
            S_WK2:
            begin
                cmd.wk_s2  = 1'b1;
                state_next = S_WK3;
            end
            S_WK3:
            begin
                cmd.wk_s3  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.req == REQ_NEXT_WEEKDAY && !sts.overflowed && sts.weekend)
                    state_next = S_NWSTEP;
                else if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.rsp_load   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and response valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

// ===== sv/cds_dp.sv =====
`default_nettype none

module cds_dp #(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cds_pkg::req_t req,
    input  wire cds_pkg::cmd_t cmd,
    output cds_pkg::sts_t      sts,
    output cds_pkg::rsp_t      rsp
);
    import cds_pkg::*;

    localparam int SUM_W = AMT_W + 1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX   = YEAR_W'(MAX_YEAR);
    localparam logic [YEAR_W-1:0]  YEAR_RST   = 14'd2000;
    localparam logic [YEAR_W-1:0]  YEAR_GREG  = 14'd1582;
    localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR  = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST  = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_LEAP   = 5'd29;
    localparam logic [DAY_W-1:0]   DAY_LAST   = 5'd31;
    localparam logic [WDAY_W-1:0]  WD_SUN     = 3'd0;
    localparam logic [WDAY_W-1:0]  WD_SAT     = 3'd6;

    // Leap test; the year modulo 25 comes from a reciprocal multiply.
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [26:0] prod;
        logic [9:0]  quo;
        logic [4:0]  rem;
        logic        m25;
        prod = 27'(y) * 27'd5243;
        quo  = prod[26:17];
        rem  = 5'(y - 14'(quo) * 14'd25);
        m25  = (rem == 5'd0);
        return ((y[1:0] == 2'd0) && !m25) || ((y[3:0] == 4'd0) && m25);
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            MONTH_FEB:                   len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:     len = 5'd30;
            default:                     len = 5'd31;
        endcase
        return len;
    endfunction

    // Month term of the congruence, floor(26 * (m + 1) / 10) for m = 3..14.
    function automatic logic [5:0] month_term(input logic [MONTH_W-1:0] m);
        logic [5:0] t;
        case (m)
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            4'd13:   t = 6'd36;
            4'd14:   t = 6'd39;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

    // Held date.
    logic [YEAR_W-1:0]  year_reg,  year_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [DAY_W-1:0]   day_reg,   day_next;
    logic               leap_reg;

    // Captured item and running count.
    req_t               item_reg;
    logic [AMT_W-1:0]   cnt_reg;
    logic [STAT_W-1:0]  status_reg;

    // Weekday pipeline.
    logic [YEAR_W-1:0]  yy_reg;
    logic [MONTH_W-1:0] mm_reg;
    logic [DAY_W-1:0]   dd_reg;
    logic [7:0]         cent_reg;
    logic               greg_reg;
    logic [10:0]        wsum_reg;
    logic [WDAY_W-1:0]  wd_reg;
    rsp_t               rsp_reg;

    logic [DAY_W-1:0]   cur_len;
    logic [SUM_W-1:0]   year_sum;
    logic               at_max;
    logic               in_leap;

    logic               early;
    logic [YEAR_W-1:0]  yy;
    logic [26:0]        prod1;
    logic [6:0]         rem100;
    logic [9:0]         gterm;
    logic [10:0]        wsum;
    logic [22:0]        prod3;
    logic [8:0]         quo7;
    logic [WDAY_W-1:0]  wd;

    assign cur_len  = month_len(month_reg, leap_reg);
    assign year_sum = SUM_W'(year_reg) + SUM_W'(item_reg.amount);
    assign at_max   = (year_reg >= YEAR_MAX);
    assign in_leap  = is_leap(item_reg.in_year);

    // Status toward the controller.
    always_comb
    begin
        sts.req        = item_reg.req_type;
        sts.cnt_zero   = (cnt_reg == '0);
        sts.load_ok    = (item_reg.in_year != '0) && (item_reg.in_year <= YEAR_MAX) &&
                         (item_reg.in_month >= MONTH_JAN) && (item_reg.in_month <= MONTH_DEC) &&
                         (item_reg.in_day >= DAY_FIRST) &&
                         (item_reg.in_day <= month_len(item_reg.in_month, in_leap));
        sts.day_ovf    = (day_reg >= cur_len) && (month_reg == MONTH_DEC) && at_max;
        sts.month_ovf  = (month_reg == MONTH_DEC) && at_max;
        sts.years_ovf  = (year_sum > SUM_W'(MAX_YEAR));
        sts.need_spill = (day_reg > cur_len);
        sts.weekend    = (wd_reg == WD_SUN) || (wd_reg == WD_SAT);
        sts.overflowed = (status_reg == ST_OVERFLOW);
    end

    // Date update.
    always_comb
    begin
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        if (cmd.saturate)
        begin
            year_next  = YEAR_MAX;
            month_next = MONTH_DEC;
            day_next   = DAY_LAST;
        end
        else if (cmd.load)
        begin
            year_next  = item_reg.in_year;
            month_next = item_reg.in_month;
            day_next   = item_reg.in_day;
        end
        else if (cmd.step_day)
        begin
            if (day_reg < cur_len)
                day_next = day_reg + 5'd1;
            else if (month_reg < MONTH_DEC)
            begin
                month_next = month_reg + 4'd1;
                day_next   = DAY_FIRST;
            end
            else
            begin
                year_next  = year_reg + 14'd1;
                month_next = MONTH_JAN;
                day_next   = DAY_FIRST;
            end
        end
        else if (cmd.step_month || cmd.spill)
        begin
            if (cmd.spill)
                day_next = day_reg - cur_len;
            if (month_reg < MONTH_DEC)
                month_next = month_reg + 4'd1;
            else
            begin
                year_next  = year_reg + 14'd1;
                month_next = MONTH_JAN;
            end
        end
        else if (cmd.add_years)
        begin
            year_next = year_sum[YEAR_W-1:0];
        end
        else if (cmd.feb_fix)
        begin
            if (month_reg == MONTH_FEB && day_reg == DAY_LEAP && !leap_reg)
            begin
                month_next = MONTH_MAR;
                day_next   = DAY_FIRST;
            end
        end
    end

    // Held date and its leap flag, which follows the year in the next cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg  <= YEAR_RST;
            month_reg <= MONTH_JAN;
            day_reg   <= DAY_FIRST;
            leap_reg  <= 1'b1;
        end
        else
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
            leap_reg  <= is_leap(year_reg);
        end
    end

    // Weekday stage one: shift January and February into the prior year.
    assign early = (month_reg <= MONTH_FEB);
    assign yy    = early ? (year_reg - 14'd1) : year_reg;
    assign prod1 = 27'(yy) * 27'd5243;

    // Weekday stage two: sum the congruence terms.
    assign rem100 = 7'(yy_reg - 14'(cent_reg) * 14'd100);
    assign gterm  = greg_reg ? (10'(cent_reg) * 10'd5 + 10'(cent_reg >> 2))
                             : (10'(cent_reg) * 10'd6 + 10'd5);
    assign wsum   = 11'(dd_reg) + 11'(month_term(mm_reg)) + 11'(rem100) +
                    11'(rem100 >> 2) + 11'(gterm) + 11'd6;

    // Weekday stage three: reduce modulo seven by reciprocal multiply.
    assign prod3 = 23'(wsum_reg) * 23'd2341;
    assign quo7  = prod3[22:14];
    assign wd    = 3'(wsum_reg - 11'(quo7) * 11'd7);

    // Item capture, count, status and weekday pipeline.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg   <= req;
            cnt_reg    <= req.amount;
            status_reg <= ST_OK;
        end
        else
        begin
            if (cmd.cnt_dec)
                cnt_reg <= cnt_reg - 16'd1;
            if (cmd.saturate)
                status_reg <= ST_OVERFLOW;
            else if (cmd.set_invalid)
                status_reg <= ST_INVALID;
        end
        if (cmd.wk_s1)
        begin
            yy_reg   <= yy;
            mm_reg   <= early ? (month_reg + 4'd12) : month_reg;
            dd_reg   <= day_reg;
            cent_reg <= prod1[26:19];
            greg_reg <= (year_reg >= YEAR_GREG);
        end
        if (cmd.wk_s2)
            wsum_reg <= wsum;
        if (cmd.wk_s3)
            wd_reg <= wd;
        if (cmd.rsp_load)
        begin
            rsp_reg.out_year  <= year_reg;
            rsp_reg.out_month <= month_reg;
            rsp_reg.out_day   <= day_reg;
            rsp_reg.weekday   <= wd_reg;
            rsp_reg.status    <= status_reg;
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

// ===== sv/calendar_date_stepper_top.sv =====
`default_nettype none

// Channel   Signals                      Item
// request   req_valid, req_stall, req    command with load date and amount
// response  rsp_valid, rsp_stall, rsp    held date, weekday and status
//
// Every command, a load or unknown one, an add of years, days or months, ends in
// the three-stage weekday unit before its response is valid. Adding n days or n
// months takes one step per cycle. Next weekday steps one day and reruns the weekday
// unit while the date falls on a weekend, at most three days in all.
// A new command is taken in the cycle after the response loads. Reset sets January 1, 2000.
// A stalled response holds in its output register while the next command runs.

module calendar_date_stepper_top #(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire cds_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output cds_pkg::rsp_t      rsp
);
    import cds_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer.
    cds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Date counter and weekday unit.
    cds_dp #(
        .MAX_YEAR (MAX_YEAR)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire
